@@ rtl/xcfe_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfe_pkg
// Types and constants shared by the XOR-checked frame extractor modules.
// ----------------------------------------------------------------------------
package xcfe_pkg;

	localparam int MAX_FRAME = 64;
	localparam int MIN_FRAME = 3;
	localparam int ADDR_W    = $clog2(MAX_FRAME);
	localparam int LEN_W     = $clog2(MAX_FRAME + 1);

	localparam logic [7:0] SYNC_RESET = 8'h55;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_last;
	} out_item_t;

	// frame parser phase
	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_LEN   = 2'd1,
		PH_BODY  = 2'd2,
		PH_CHECK = 2'd3
	} phase_t;

	// controller state
	typedef enum logic [1:0] {
		ST_SCAN = 2'd0,
		ST_READ = 2'd1,
		ST_LOAD = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic accept;  // input beat taken this cycle
		logic rd_en;   // read frame store at replay index
		logic load;    // load output register from read data
		logic rd_adv;  // advance replay index
	} cmd_t;

	typedef struct packed {
		logic frame_ok;  // current input beat completes a good frame
		logic rd_last;   // replay index is on the check byte
	} sts_t;

endpackage

@@ rtl/xor_checked_frame_extractor_top.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_extractor_top
// Byte-stream frame extractor with sync byte, length byte and XOR check.
//
// Input channel in_valid/in_stall/in_data carries one stream byte per beat,
// with stream_end marking the final byte of a stream. Bytes are parsed at one
// beat per cycle while the input is not stalled. When a check byte completes a
// good frame of N bytes, the input stalls while the frame is replayed from the
// frame store on out_valid/out_stall/out_data, frame_last set on the check
// byte. Each byte is replayed by a store read and then an output register
// load, and the input stays stalled until the check byte is loaded; a stalled
// output holds replay where it stands.
// Bad frames and stray bytes produce nothing and do not stall the input.
// The cfg channel writes the sync byte; it is always ready.
// Reset returns the parser to hunting, empties the output register and sets
// the sync byte to 0x55.
// ----------------------------------------------------------------------------
module xor_checked_frame_extractor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  xcfe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output xcfe_pkg::out_item_t out_data
);
	import xcfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	xcfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	xcfe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	a_good_frame_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sts.frame_ok) |=> in_stall)
		else $error("good frame did not start replay");

	a_resume_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> ($past(cmd.load) && $past(sts.rd_last)))
		else $error("input resumed before frame replay finished");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (out_valid && out_data.frame_last == $past(sts.rd_last)))
		else $error("output register load lost");
`endif

endmodule

@@ rtl/xcfe_dp.sv @@
// ----------------------------------------------------------------------------
// xcfe_dp
// Datapath: sync register, frame parser, running XOR, frame store and
// output register.
// ----------------------------------------------------------------------------
module xcfe_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [7:0]         cfg_data,
	input  xcfe_pkg::in_item_t in_data,
	input  xcfe_pkg::cmd_t     cmd,
	output xcfe_pkg::sts_t     sts,
	output xcfe_pkg::out_item_t out_data
);
	import xcfe_pkg::*;

	logic [7:0]        sync_q;
	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [7:0]        xor_q, xor_d;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] rd_idx_q;
	logic [7:0]        rd_data_q;
	out_item_t         out_q;
	logic [7:0]        mem [MAX_FRAME];

	logic [7:0] b;
	assign b = in_data.in_byte;

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		xor_d   = xor_q;
		we      = 1'b0;
		waddr   = cnt_q;
		case (phase_q)
			PH_HUNT: begin
				if (b == sync_q) begin
					we      = 1'b1;
					waddr   = '0;
					cnt_d   = ADDR_W'(1);
					xor_d   = b;
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (b < 8'(MIN_FRAME) || b > 8'(MAX_FRAME)) begin
					phase_d = PH_HUNT;
				end else begin
					we      = 1'b1;
					cnt_d   = cnt_q + ADDR_W'(1);
					xor_d   = xor_q ^ b;
					len_d   = LEN_W'(b);
					phase_d = (b == 8'(MIN_FRAME)) ? PH_CHECK : PH_BODY;
				end
			end
			PH_BODY: begin
				we    = 1'b1;
				cnt_d = cnt_q + ADDR_W'(1);
				xor_d = xor_q ^ b;
				// this beat plus the check byte fill the frame
				if (LEN_W'(cnt_q) + LEN_W'(2) >= len_q)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				// store the check byte too, so replay reads it back
				we      = 1'b1;
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		if (in_data.stream_end)
			phase_d = PH_HUNT;
	end

	assign sts.frame_ok = (phase_q == PH_CHECK) && (b == xor_q);
	assign sts.rd_last  = (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;
	assign out_data     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q   <= SYNC_RESET;
			phase_q  <= PH_HUNT;
			len_q    <= '0;
			cnt_q    <= '0;
			xor_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cfg_valid)
				sync_q <= cfg_data;
			if (cmd.accept) begin
				phase_q  <= phase_d;
				len_q    <= len_d;
				cnt_q    <= cnt_d;
				xor_q    <= xor_d;
				rd_idx_q <= '0;
			end else if (cmd.rd_adv) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && we)
			mem[waddr] <= b;
		if (cmd.rd_en)
			rd_data_q <= mem[rd_idx_q];
		if (cmd.load) begin
			out_q.out_byte   <= rd_data_q;
			out_q.frame_last <= sts.rd_last;
		end
	end

endmodule

@@ rtl/xcfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// xcfe_ctrl
// Controller: takes input beats while scanning, then replays a good frame
// from the store byte by byte, a read then a load, holding while out stalls.
// ----------------------------------------------------------------------------
module xcfe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  xcfe_pkg::sts_t sts,
	output xcfe_pkg::cmd_t cmd
);
	import xcfe_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	assign in_stall  = (state_q != ST_SCAN);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			ST_SCAN: begin
				cmd.accept = in_valid;
				if (in_valid && sts.frame_ok)
					state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.load    = 1'b1;
					out_valid_d = 1'b1;
					if (sts.rd_last) begin
						state_d = ST_SCAN;
					end else begin
						cmd.rd_adv = 1'b1;
						state_d    = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_SCAN;
			end
		endcase
	end

endmodule
